>>> src/lfbp_pkg.sv
// ----------------------------------------------------------------------------
// lfbp_pkg
// Shared types and constants of the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lfbp_pkg;

  localparam int unsigned MAX_FIELD_BITS_DEF   = 64;
  localparam int unsigned TOTAL_BITS_WIDTH_DEF = 32;

  localparam int unsigned KIND_W        = 2;
  localparam int unsigned FIELD_VALUE_W = 64;
  localparam int unsigned FIELD_WIDTH_W = 7;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned BYTE_MSB      = BYTE_W - 1;
  localparam int unsigned HELD_W        = 3;
  localparam int unsigned BITS_OUT_W    = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_ALIGN = 2'd1,
    KIND_RAW   = 2'd2,
    KIND_RESET = 2'd3
  } kind_e;

  // operation the shifter carries out for the item in flight
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_WRITE = 3'd1,
    OP_ALIGN = 3'd2,
    OP_RAW   = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    logic              load;
    op_e               op;
    logic [HELD_W-1:0] rem;
    logic              emit;
    logic              step;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [HELD_W-1:0] held;
    logic [BYTE_W-1:0] res_byte;
    logic              res_valid;
  } shf_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     out_byte;
    logic                  byte_valid;
    logic                  last;
    logic [BITS_OUT_W-1:0] bits_written;
    logic                  bad_width;
  } res_t;

endpackage

>>> src/lfbp_in_if.sv
// ----------------------------------------------------------------------------
// lfbp_in_if
// Request channel into the packer: valid/ready plus one input item.
// ----------------------------------------------------------------------------
interface lfbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] field_value;
  logic [6:0]  field_width;
  logic        discard_partial;

  modport source (output valid, kind, field_value, field_width, discard_partial,
                  input ready);
  modport sink   (input valid, kind, field_value, field_width, discard_partial,
                  output ready);
endinterface

>>> src/lfbp_out_if.sv
// ----------------------------------------------------------------------------
// lfbp_out_if
// Result channel out of the packer: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface lfbp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [31:0] bits_written;
  logic        bad_width;

  modport source (output valid, out_byte, byte_valid, last, bits_written, bad_width,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, last, bits_written, bad_width,
                  output ready);
endinterface

>>> src/lsb_first_bit_packer_core.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_core
// Packs 1..MAX_FIELD_BITS-bit fields LSB first into a byte stream.
// ----------------------------------------------------------------------------
// A request is taken while idle; its results then leave one per cycle while
// the sink takes them, one stream byte per step out of the shift register of
// MAX_FIELD_BITS bits. An item gives n results: max(1, (held + width) / 8)
// for a legal write (width 1..MAX_FIELD_BITS), 1 or 2 for a raw byte, else 1.
// The output register lets the next request be taken while the last result
// still waits; a stalled sink holds the shifter. bits_written on every result
// is the total after the whole request.
module lsb_first_bit_packer_core #(
  parameter int unsigned MAX_FIELD_BITS   = lfbp_pkg::MAX_FIELD_BITS_DEF,
  parameter int unsigned TOTAL_BITS_WIDTH = lfbp_pkg::TOTAL_BITS_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfbp_in_if.sink     in_i,
  lfbp_out_if.source  out_o
);
  import lfbp_pkg::*;

  state_e state_q, state_d;
  logic   in_ready, step, can_load, accept, last;

  logic [HELD_W-1:0]           cnt_q, cnt_d;
  logic [TOTAL_BITS_WIDTH-1:0] total_q, total_d;
  logic                        bad_q, bad_d;
  logic [63:0]                 total_ext;

  shf_status_t               shf_st;
  cmd_t                      cmd;
  logic [MAX_FIELD_BITS-1:0] load_value;
  logic [FIELD_VALUE_W-1:0]  masked;
  logic [BYTE_W-1:0]         sum;
  logic [4:0]                nbytes;
  logic                      w_ok;
  logic [3:0]                pad;
  op_e                       op;
  res_t                      res;

  assign accept = in_i.valid && in_ready;
  assign last   = (cnt_q == '0);

  // request decode
  assign w_ok   = (in_i.field_width != '0) &&
                  (in_i.field_width <= FIELD_WIDTH_W'(MAX_FIELD_BITS));
  assign masked = in_i.field_value & ~({FIELD_VALUE_W{1'b1}} << in_i.field_width);
  assign sum    = {1'b0, in_i.field_width} + BYTE_W'(shf_st.held);
  assign nbytes = sum[7:3];
  assign pad    = (shf_st.held != '0) ? (4'(BYTE_W) - {1'b0, shf_st.held}) : 4'd0;

  always_comb begin
    op         = OP_NONE;
    cnt_d      = cnt_q;
    total_d    = total_q;
    bad_d      = bad_q;
    load_value = MAX_FIELD_BITS'(in_i.field_value);
    if (accept) begin
      bad_d = 1'b0;
      cnt_d = '0;
      unique case (kind_e'(in_i.kind))
        KIND_WRITE: begin
          if (w_ok) begin
            op         = OP_WRITE;
            load_value = MAX_FIELD_BITS'(masked);
            total_d    = total_q + TOTAL_BITS_WIDTH'(in_i.field_width);
            if (nbytes != '0) cnt_d = HELD_W'(nbytes - 5'd1);
          end else begin
            bad_d = 1'b1;
          end
        end
        KIND_ALIGN: begin
          op      = OP_ALIGN;
          total_d = total_q + TOTAL_BITS_WIDTH'(pad);
        end
        KIND_RAW: begin
          op      = OP_RAW;
          total_d = total_q + TOTAL_BITS_WIDTH'(pad) + TOTAL_BITS_WIDTH'(BYTE_W);
          cnt_d   = (shf_st.held != '0) ? HELD_W'(1) : '0;
        end
        KIND_RESET: begin
          op      = in_i.discard_partial ? OP_CLEAR : OP_NONE;
          total_d = '0;
        end
        default: ;
      endcase
    end else if (step && !last) begin
      cnt_d = cnt_q - HELD_W'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RUN;
      ST_RUN:  if (step && last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    step     = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN:  step     = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      total_q <= '0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      bad_q   <= bad_d;
    end
  end

  assign in_i.ready = in_ready;

  assign cmd.load = accept;
  assign cmd.op   = op;
  assign cmd.rem  = sum[2:0];
  assign cmd.emit = (nbytes != '0);
  assign cmd.step = step;
  assign cmd.last = last;

  lfbp_shifter #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_shifter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .value_i  (load_value),
    .status_o (shf_st)
  );

  assign total_ext        = 64'(total_q);
  assign res.out_byte     = shf_st.res_byte;
  assign res.byte_valid   = shf_st.res_valid;
  assign res.last         = last;
  assign res.bits_written = total_ext[BITS_OUT_W-1:0];
  assign res.bad_width    = bad_q;

  lfbp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("request taken while previous one still in flight");

  a_empty_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.byte_valid) |-> (out_o.out_byte == '0))
    else $error("result without byte carries non-zero data");

  a_bad_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_width) |-> (out_o.last && !out_o.byte_valid))
    else $error("rejected write gave more than a single empty result");

  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept || step) |=> $stable(shf_st.held))
    else $error("held bit count moved without a step");
`endif

endmodule

>>> src/lfbp_shifter.sv
// ----------------------------------------------------------------------------
// lfbp_shifter
// Byte-digit shift register and partial byte: one stream byte per step.
// ----------------------------------------------------------------------------
module lfbp_shifter #(
  parameter int unsigned MAX_FIELD_BITS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lfbp_pkg::cmd_t            cmd_i,
  input  logic [MAX_FIELD_BITS-1:0] value_i,
  output lfbp_pkg::shf_status_t     status_o
);
  import lfbp_pkg::*;

  logic [MAX_FIELD_BITS-1:0] sr_q, sr_d;
  logic [BYTE_W-1:0]         part_q, part_d;
  logic [HELD_W-1:0]         held_q, held_d;
  op_e                       op_q, op_d;
  logic [HELD_W-1:0]         rem_q, rem_d;
  logic                      emit_q, emit_d;

  logic [MAX_FIELD_BITS-1:0] sr_sh;
  logic [BYTE_W-1:0]         digit, merge, carry, merge_nxt, res_byte;
  logic                      res_valid;

  assign digit = sr_q[BYTE_MSB:0];
  assign sr_sh = sr_q >> BYTE_W;
  assign merge = part_q | (digit << held_q);
  // top bits of the digit that spill past the emitted byte
  assign carry = digit >> (4'(BYTE_W) - {1'b0, held_q});
  assign merge_nxt = carry | (sr_sh[BYTE_MSB:0] << held_q);

  always_comb begin
    sr_d      = sr_q;
    part_d    = part_q;
    held_d    = held_q;
    op_d      = op_q;
    rem_d     = rem_q;
    emit_d    = emit_q;
    res_byte  = '0;
    res_valid = 1'b0;
    unique case (op_q)
      OP_WRITE: begin
        res_valid = emit_q;
        res_byte  = emit_q ? merge : '0;
        if (cmd_i.step) begin
          if (emit_q) begin
            sr_d   = sr_sh;
            part_d = cmd_i.last ? merge_nxt : carry;
          end else begin
            part_d = merge;
          end
          if (cmd_i.last) held_d = rem_q;
        end
      end
      OP_ALIGN: begin
        res_valid = (held_q != '0);
        res_byte  = res_valid ? part_q : '0;
        if (cmd_i.step) begin
          part_d = '0;
          held_d = '0;
        end
      end
      OP_RAW: begin
        res_valid = 1'b1;
        res_byte  = (held_q != '0) ? part_q : digit;
        if (cmd_i.step) begin
          part_d = '0;
          held_d = '0;
        end
      end
      OP_CLEAR: begin
        if (cmd_i.step) begin
          part_d = '0;
          held_d = '0;
        end
      end
      default: ;
    endcase
    if (cmd_i.load) begin
      sr_d   = value_i;
      op_d   = cmd_i.op;
      rem_d  = cmd_i.rem;
      emit_d = cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      held_q <= '0;
      op_q   <= OP_NONE;
    end else begin
      part_q <= part_d;
      held_q <= held_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q   <= sr_d;
    rem_q  <= rem_d;
    emit_q <= emit_d;
  end

  assign status_o.held      = held_q;
  assign status_o.res_byte  = res_byte;
  assign status_o.res_valid = res_valid;

endmodule

>>> src/lfbp_out_reg.sv
// ----------------------------------------------------------------------------
// lfbp_out_reg
// Output register for result items; frees on the same edge it is taken.
// ----------------------------------------------------------------------------
module lfbp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lfbp_pkg::res_t      res_i,
  output logic                can_load_o,
  lfbp_out_if.source          out_o
);
  import lfbp_pkg::*;

  logic full_q, full_d;
  res_t res_q;

  assign can_load_o = !full_q || out_o.ready;
  assign full_d     = load_i || (full_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_o.valid        = full_q;
  assign out_o.out_byte     = res_q.out_byte;
  assign out_o.byte_valid   = res_q.byte_valid;
  assign out_o.last         = res_q.last;
  assign out_o.bits_written = res_q.bits_written;
  assign out_o.bad_width    = res_q.bad_width;

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lsb_first_bit_packer_core. A driver feeds queued
// requests (a directed set, then random traffic) with random gaps. A monitor
// accepts results with random stalls and one long hold-off. Each result is
// compared field by field against a bit-level prediction of the packer.
// ----------------------------------------------------------------------------
module tb;
  import lfbp_pkg::*;

  localparam int unsigned N_RANDOM   = 320;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned HOLD_OFF   = 400;
  localparam int unsigned HOLD_AT    = 120;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    logic [6:0]  width;
    logic        discard;
  } request_t;

  logic clk_i;
  logic rst_ni;

  lfbp_in_if  in_if ();
  lfbp_out_if out_if ();

  lsb_first_bit_packer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  request_t pending_requests[$];
  res_t     expected_results[$];

  // predicted packer state
  logic [BYTE_W-1:0]     partial_q;
  logic [HELD_W-1:0]     held_q;
  logic [BITS_OUT_W-1:0] bit_total_q;

  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned recv_wait;
  int unsigned results_seen;
  int unsigned wait_draw;
  logic        send_burst;
  logic        recv_burst;
  logic        hold_done;
  request_t    next_req;

  function automatic res_t byte_result(logic [7:0] b, logic valid, logic bad);
    res_t r;
    r.out_byte     = b;
    r.byte_valid   = valid;
    r.last         = 1'b0;
    r.bits_written = '0;
    r.bad_width    = bad;
    return r;
  endfunction

  function automatic int unsigned draw_wait(logic burst);
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  // pad out the held bits and emit them as one byte
  function automatic void flush_partial(ref res_t batch[$]);
    if (held_q != '0) begin
      bit_total_q += BITS_OUT_W'(BYTE_W - held_q);
      batch.push_back(byte_result(partial_q, 1'b1, 1'b0));
      partial_q = '0;
      held_q    = '0;
    end
  endfunction

  function automatic void predict_packing(request_t req);
    res_t        batch[$];
    logic [63:0] masked;
    logic [71:0] acc;
    int unsigned span;
    int unsigned nbytes;
    case (req.kind)
      KIND_WRITE: begin
        if (req.width == '0 || req.width > MAX_FIELD_BITS_DEF) begin
          batch.push_back(byte_result('0, 1'b0, 1'b1));
        end else begin
          masked = (req.width == 7'd64) ? req.value
                                        : req.value & ((64'd1 << req.width) - 64'd1);
          acc    = ({8'd0, masked} << held_q) | {64'd0, partial_q};
          span   = int'(held_q) + int'(req.width);
          nbytes = span / BYTE_W;
          for (int k = 0; k < nbytes; k++)
            batch.push_back(byte_result(acc[8*k +: 8], 1'b1, 1'b0));
          held_q      = HELD_W'(span % BYTE_W);
          partial_q   = acc[8*nbytes +: 8] & ((8'd1 << held_q) - 8'd1);
          bit_total_q += BITS_OUT_W'(req.width);
        end
      end
      KIND_ALIGN: flush_partial(batch);
      KIND_RAW: begin
        flush_partial(batch);
        batch.push_back(byte_result(req.value[7:0], 1'b1, 1'b0));
        bit_total_q += BITS_OUT_W'(BYTE_W);
      end
      default: begin
        if (req.discard) begin
          partial_q = '0;
          held_q    = '0;
        end
        bit_total_q = '0;
      end
    endcase
    if (batch.size() == 0) batch.push_back(byte_result('0, 1'b0, 1'b0));
    foreach (batch[k]) begin
      batch[k].last         = (k == batch.size() - 1);
      batch[k].bits_written = bit_total_q;
      expected_results.push_back(batch[k]);
    end
  endfunction

  task automatic check_result(res_t got);
    res_t exp;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: out_byte %h last %b", got.out_byte, got.last);
      errors++;
    end else begin
      exp = expected_results.pop_front();
      if (got.out_byte !== exp.out_byte) begin
        $error("out_byte exp %h got %h", exp.out_byte, got.out_byte);
        errors++;
      end
      if (got.byte_valid !== exp.byte_valid) begin
        $error("byte_valid exp %b got %b", exp.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last exp %b got %b", exp.last, got.last);
        errors++;
      end
      if (got.bits_written !== exp.bits_written) begin
        $error("bits_written exp %0d got %0d", exp.bits_written, got.bits_written);
        errors++;
      end
      if (got.bad_width !== exp.bad_width) begin
        $error("bad_width exp %b got %b", exp.bad_width, got.bad_width);
        errors++;
      end
    end
  endtask

  function automatic void add_request(kind_e kind, logic [63:0] value, logic [6:0] width,
                                      logic discard);
    request_t req;
    req.kind    = kind;
    req.value   = value;
    req.width   = width;
    req.discard = discard;
    pending_requests.push_back(req);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid           <= 1'b0;
      in_if.kind            <= KIND_WRITE;
      in_if.field_value     <= '0;
      in_if.field_width     <= '0;
      in_if.discard_partial <= 1'b0;
      send_gap              <= 0;
      send_burst            <= 1'b0;
      partial_q             <= '0;
      held_q                <= '0;
      bit_total_q           <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        predict_packing('{kind_e'(in_if.kind), in_if.field_value, in_if.field_width,
                          in_if.discard_partial});
      if (in_if.valid && !in_if.ready) begin
        // request still waiting, hold it
      end else if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (pending_requests.size() != 0) begin
        next_req               = pending_requests.pop_front();
        in_if.valid           <= 1'b1;
        in_if.kind            <= next_req.kind;
        in_if.field_value     <= next_req.value;
        in_if.field_width     <= next_req.width;
        in_if.discard_partial <= next_req.discard;
        send_gap              <= draw_wait(send_burst);
        if ($urandom_range(0, 15) == 0) send_burst <= ~send_burst;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_wait    <= 0;
      results_seen <= 0;
      recv_burst   <= 1'b0;
      hold_done    <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      check_result('{out_if.out_byte, out_if.byte_valid, out_if.last, out_if.bits_written,
                     out_if.bad_width});
      results_seen <= results_seen + 1;
      if ($urandom_range(0, 15) == 0) recv_burst <= ~recv_burst;
      if (!hold_done && results_seen == HOLD_AT) begin
        // long back-pressure so the packer fills and stalls its input
        hold_done    <= 1'b1;
        out_if.ready <= 1'b0;
        recv_wait    <= HOLD_OFF - 1;
      end else begin
        wait_draw = draw_wait(recv_burst);
        if (wait_draw == 0) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          recv_wait    <= wait_draw - 1;
        end
      end
    end else if (recv_wait > 0) begin
      out_if.ready <= 1'b0;
      recv_wait    <= recv_wait - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    kind_e       kind;
    logic [63:0] value;
    logic [6:0]  width;
    errors = 0;
    rst_ni = 1'b0;

    // bad widths first, nothing held
    add_request(KIND_WRITE, '1, 7'd0, 1'b0);
    add_request(KIND_WRITE, '1, 7'd127, 1'b0);
    add_request(KIND_WRITE, '1, 7'd65, 1'b0);
    add_request(KIND_ALIGN, '1, 7'd0, 1'b0);
    add_request(KIND_WRITE, 64'd1, 7'd1, 1'b0);
    // full 64 bits above one held bit spills into the top byte
    add_request(KIND_WRITE, '1, 7'd64, 1'b0);
    add_request(KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFF5, 7'd3, 1'b0);
    add_request(KIND_ALIGN, '0, 7'd0, 1'b0);
    add_request(KIND_RAW, 64'hFFFF_FFFF_FFFF_FFA5, 7'd0, 1'b0);
    add_request(KIND_WRITE, 64'h7F, 7'd7, 1'b1);
    add_request(KIND_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 7'd64, 1'b0);
    add_request(KIND_RAW, 64'h3C, 7'd64, 1'b1);
    add_request(KIND_WRITE, 64'h15, 7'd5, 1'b0);
    // reset keeping the partial byte, then complete it
    add_request(KIND_RESET, '1, 7'd64, 1'b0);
    add_request(KIND_WRITE, 64'h7, 7'd3, 1'b0);
    add_request(KIND_WRITE, 64'h2B, 7'd6, 1'b0);
    add_request(KIND_RESET, '0, 7'd0, 1'b1);
    add_request(KIND_ALIGN, '1, 7'd127, 1'b1);
    add_request(KIND_WRITE, '0, 7'd8, 1'b0);
    add_request(KIND_WRITE, '0, 7'd64, 1'b0);
    add_request(KIND_WRITE, 64'h8000_0000_0000_0001, 7'd64, 1'b0);
    add_request(KIND_RESET, '1, 7'd1, 1'b1);
    add_request(KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFF3, 7'd4, 1'b1);

    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 62)      kind = KIND_WRITE;
      else if (pick < 74) kind = KIND_ALIGN;
      else if (pick < 88) kind = KIND_RAW;
      else                kind = KIND_RESET;
      value = {$urandom, $urandom};
      pick  = $urandom_range(0, 19);
      if (pick == 0)      value = '1;
      else if (pick == 1) value = '0;
      pick = $urandom_range(0, 99);
      if (pick < 3)       width = 7'd0;
      else if (pick < 6)  width = 7'($urandom_range(65, 127));
      else if (pick < 16) width = 7'd64;
      else if (pick < 50) width = 7'($urandom_range(1, 9));
      else                width = 7'($urandom_range(1, 64));
      add_request(kind, value, width, 1'($urandom_range(0, 1)));
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_requests.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
